// ===== rtl/ptc_pkg.sv =====
package ptc_pkg;

  typedef enum logic [2:0] {
    CFG_MODEL_SELECT  = 3'd0,
    CFG_SENS          = 3'd1,
    CFG_OFFSET        = 3'd2,
    CFG_SENS_TEMPCO   = 3'd3,
    CFG_OFFSET_TEMPCO = 3'd4,
    CFG_REF_TEMP      = 3'd5,
    CFG_TEMP_COEF     = 3'd6
  } cfg_index_t;

  // Magnitude of the pressure value before the final decimal scaling.
  localparam int MAG_W     = 27;
  // Reciprocal multiply for the decimal scaling: q ~= (m * floor(2^32 / d)) >> 32.
  localparam int RECIP_W   = 29;
  localparam int DIV_SHIFT = 32;
  localparam int QUO_W     = MAG_W + RECIP_W - DIV_SHIFT;
  localparam int REM_W     = 8;
  localparam logic [RECIP_W-1:0] RECIP_TEN     = 29'd429496729;
  localparam logic [RECIP_W-1:0] RECIP_HUNDRED = 29'd42949672;
  localparam logic [6:0]         DIV_TEN       = 7'd10;
  localparam logic [6:0]         DIV_HUNDRED   = 7'd100;

  localparam logic signed [19:0] TEMP_REF      = 20'sd2000;
  localparam logic signed [19:0] TEMP_VERY_LOW = -20'sd1600;
  localparam logic signed [20:0] TEMP_VLOW_OFS = 21'sd1500;

  // Signed division by 2^k that truncates toward zero.
  function automatic logic signed [63:0] sdiv_pow2(input logic signed [63:0] x,
                                                   input logic [5:0] k);
    logic signed [63:0] bias;
    bias = x[63] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
    return (x + bias) >>> k;
  endfunction

endpackage

// ===== rtl/ptc_cdiv.sv =====
module ptc_cdiv (
  input  logic                      clk,
  input  logic                      en,
  input  logic                      sel_ten,
  input  logic                      neg,
  input  logic [ptc_pkg::MAG_W-1:0] mag,
  output logic signed [31:0]        quo
);
  import ptc_pkg::*;

  logic [MAG_W+RECIP_W-1:0] prod_a;
  logic [MAG_W-1:0]         mag_a;
  logic                     neg_a;
  logic [QUO_W-1:0]         q_b;
  logic [REM_W-1:0]         rem_b;
  logic                     neg_b;

  logic [RECIP_W-1:0]       recip;
  logic [6:0]               dv;
  logic [QUO_W-1:0]         q0;
  logic [QUO_W+6:0]         qd;
  logic [MAG_W-1:0]         rem_full;
  logic [QUO_W-1:0]         q_fix;
  logic [31:0]              q_ext;

  always_comb begin
    recip    = sel_ten ? RECIP_TEN : RECIP_HUNDRED;
    dv       = sel_ten ? DIV_TEN : DIV_HUNDRED;
    q0       = prod_a[MAG_W+RECIP_W-1:DIV_SHIFT];
    qd       = q0 * dv;
    rem_full = mag_a - qd[MAG_W-1:0];
    q_fix    = q_b + QUO_W'(rem_b >= REM_W'(dv));
    q_ext    = 32'(q_fix);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= (MAG_W+RECIP_W)'(mag) * (MAG_W+RECIP_W)'(recip);
      mag_a  <= mag;
      neg_a  <= neg;
      q_b    <= q0;
      rem_b  <= rem_full[REM_W-1:0];
      neg_b  <= neg_a;
      quo    <= neg_b ? -q_ext : q_ext;
    end
  end

endmodule

// ===== rtl/pressure_temperature_compensation.sv =====
// Throughput: one item per cycle; a stalled output holds every stage in place.
// The pipeline length is set by the two-part pressure product and the
// three-stage reciprocal scaling of the pressure value.
// Reset (synchronous, active high) empties the pipeline and sets model_select
// to 1 and all calibration words to 0.
module pressure_temperature_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,   // raw_temperature, raw_pressure
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // pressure_value, temperature_centi
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import ptc_pkg::*;

  localparam int NUM_STG  = 13;
  localparam int TEMP_DLY = 9;

  logic        model_select;
  logic [15:0] cal_sens, cal_offset, cal_sens_tempco, cal_offset_tempco;
  logic [15:0] cal_ref_temp, cal_temp_coef;

  logic [NUM_STG-1:0] vld;
  logic               adv;

  logic [23:0]        d1_s1, d1_s2, d1_s3, d1_s4, d1_s5, d1_s6;
  logic signed [24:0] dt_s1;
  logic signed [41:0] p3_s2, p4_s2, p6_s2;
  logic [48:0]        sq_s2;
  logic signed [35:0] sens_s3, sens_s4, sens_s5, sens_s6;
  logic signed [36:0] off_s3, off_s4, off_s5, off_s6, off_s7, off_s8;
  logic signed [19:0] dtemp_s3, temp_s3;
  logic [17:0]        ti_small_s3, ti_blow_s3, ti_bhigh_s3;
  logic [35:0]        dsq_s4, vsq_s4;
  logic               low_s4, vlow_s4;
  logic signed [31:0] temp_s4;
  logic signed [31:0] offi_s5, sensi_s5;
  logic [41:0]        pl_s7;
  logic signed [42:0] ph_s7;
  logic signed [61:0] prod_s8;
  logic signed [40:0] t1_s9;
  logic               neg_s10;
  logic [MAG_W-1:0]   mag_s10;
  logic signed [31:0] temp_line [TEMP_DLY];
  logic signed [31:0] quo;

  logic               big;
  logic signed [24:0] dt_full;
  logic signed [41:0] p3_full, p4_full, p6_full;
  logic signed [49:0] sq_full;
  logic signed [63:0] sens_full, off_full, dtemp_full;
  logic [63:0]        ti_small_full, ti_blow_full, ti_bhigh_full;
  logic signed [19:0] temp_full;
  logic signed [39:0] dsq_full;
  logic signed [20:0] v_full;
  logic signed [41:0] vsq_full;
  logic [17:0]        ti_sel;
  logic signed [31:0] tout;
  logic [63:0]        dsq64, vsq64, offi64, sensi64;
  logic signed [61:0] prod_full;
  logic signed [63:0] t1_full, y_full, mag_full;

  assign big      = model_select;
  assign adv      = !vld[NUM_STG-1] || m_tready;
  assign s_tready = adv;
  assign m_tvalid = vld[NUM_STG-1];
  assign m_tdata  = {quo, temp_line[TEMP_DLY-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      model_select      <= 1'b1;
      cal_sens          <= '0;
      cal_offset        <= '0;
      cal_sens_tempco   <= '0;
      cal_offset_tempco <= '0;
      cal_ref_temp      <= '0;
      cal_temp_coef     <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODEL_SELECT:  model_select      <= cfg_data[0];
        CFG_SENS:          cal_sens          <= cfg_data;
        CFG_OFFSET:        cal_offset        <= cfg_data;
        CFG_SENS_TEMPCO:   cal_sens_tempco   <= cfg_data;
        CFG_OFFSET_TEMPCO: cal_offset_tempco <= cfg_data;
        CFG_REF_TEMP:      cal_ref_temp      <= cfg_data;
        CFG_TEMP_COEF:     cal_temp_coef     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NUM_STG-2:0], s_tvalid};
    end
  end

  always_comb begin
    dt_full = $signed({1'b0, s_tdata[47:24]}) - $signed({1'b0, cal_ref_temp, 8'd0});

    p3_full = $signed({1'b0, cal_sens_tempco}) * dt_s1;
    p4_full = $signed({1'b0, cal_offset_tempco}) * dt_s1;
    p6_full = $signed({1'b0, cal_temp_coef}) * dt_s1;
    sq_full = dt_s1 * dt_s1;

    sens_full = (big ? ({48'd0, cal_sens} << 15) : ({48'd0, cal_sens} << 16))
              + sdiv_pow2(64'(p3_s2), big ? 6'd8 : 6'd7);
    off_full  = (big ? ({48'd0, cal_offset} << 16) : ({48'd0, cal_offset} << 17))
              + sdiv_pow2(64'(p4_s2), big ? 6'd7 : 6'd6);
    dtemp_full    = sdiv_pow2(64'(p6_s2), 6'd23);
    temp_full     = dtemp_full[19:0] + TEMP_REF;
    ti_small_full = (64'(sq_s2) * 64'd11) >> 35;
    ti_blow_full  = (64'(sq_s2) * 64'd3) >> 33;
    ti_bhigh_full = 64'(sq_s2) >> 36;

    dsq_full = dtemp_s3 * dtemp_s3;
    v_full   = 21'(temp_s3) + TEMP_VLOW_OFS;
    vsq_full = v_full * v_full;
    if (!big) begin
      ti_sel = (temp_s3 < TEMP_REF) ? ti_small_s3 : 18'd0;
    end else begin
      ti_sel = (temp_s3 < TEMP_REF) ? ti_blow_s3 : ti_bhigh_s3;
    end
    tout = 32'(temp_s3) - $signed({14'd0, ti_sel});

    dsq64 = 64'(dsq_s4);
    vsq64 = 64'(vsq_s4);
    if (!big) begin
      if (low_s4) begin
        offi64  = (dsq64 * 64'd31) >> 3;
        sensi64 = (dsq64 * 64'd63) >> 5;
      end else begin
        offi64  = '0;
        sensi64 = '0;
      end
    end else if (low_s4) begin
      offi64  = ((dsq64 * 64'd3) >> 1) + (vlow_s4 ? vsq64 * 64'd7 : 64'd0);
      sensi64 = ((dsq64 * 64'd5) >> 3) + (vlow_s4 ? vsq64 << 2 : 64'd0);
    end else begin
      offi64  = dsq64 >> 4;
      sensi64 = '0;
    end

    prod_full = (62'(ph_s7) <<< 18) + 62'(pl_s7);
    t1_full   = sdiv_pow2(64'(prod_s8), 6'd21) - 64'(off_s8);
    y_full    = sdiv_pow2(64'(t1_s9), big ? 6'd13 : 6'd15);
    mag_full  = y_full[63] ? -y_full : y_full;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d1_s1 <= s_tdata[23:0];
      dt_s1 <= dt_full;

      d1_s2 <= d1_s1;
      p3_s2 <= p3_full;
      p4_s2 <= p4_full;
      p6_s2 <= p6_full;
      sq_s2 <= sq_full[48:0];

      d1_s3       <= d1_s2;
      sens_s3     <= sens_full[35:0];
      off_s3      <= off_full[36:0];
      dtemp_s3    <= dtemp_full[19:0];
      temp_s3     <= temp_full;
      ti_small_s3 <= ti_small_full[17:0];
      ti_blow_s3  <= ti_blow_full[17:0];
      ti_bhigh_s3 <= ti_bhigh_full[17:0];

      d1_s4   <= d1_s3;
      sens_s4 <= sens_s3;
      off_s4  <= off_s3;
      dsq_s4  <= dsq_full[35:0];
      vsq_s4  <= vsq_full[35:0];
      low_s4  <= temp_s3 < TEMP_REF;
      vlow_s4 <= temp_s3 <= TEMP_VERY_LOW;
      temp_s4 <= tout;

      d1_s5    <= d1_s4;
      sens_s5  <= sens_s4;
      off_s5   <= off_s4;
      offi_s5  <= offi64[31:0];
      sensi_s5 <= sensi64[31:0];

      d1_s6   <= d1_s5;
      sens_s6 <= sens_s5 - 36'(sensi_s5);
      off_s6  <= off_s5 - 37'(offi_s5);

      pl_s7  <= 42'(d1_s6) * 42'(sens_s6[17:0]);
      ph_s7  <= $signed({1'b0, d1_s6}) * $signed(sens_s6[35:18]);
      off_s7 <= off_s6;

      prod_s8 <= prod_full;
      off_s8  <= off_s7;

      t1_s9 <= t1_full[40:0];

      neg_s10 <= y_full[63];
      mag_s10 <= mag_full[MAG_W-1:0];

      temp_line[0] <= temp_s4;
      for (int i = 1; i < TEMP_DLY; i++) begin
        temp_line[i] <= temp_line[i-1];
      end
    end
  end

  ptc_cdiv u_cdiv (
    .clk     (clk),
    .en      (adv),
    .sel_ten (big),
    .neg     (neg_s10),
    .mag     (mag_s10),
    .quo     (quo)
  );

endmodule
